// File: sv/cbpe_pkg.sv
// Package for the cubic Bezier point evaluator: fixed-point widths, payload
// structs, the weight vector type and the stage advance struct. No dependencies.
package cbpe_pkg;

	// Fraction bits of the curve parameter and the weights; 1 << FRAC_BITS is 1.0.
	localparam int FRAC_BITS = 9;
	localparam int COORD_W   = 16;
	localparam int T_W       = 10;
	localparam int Q_W       = 2 * T_W;
	localparam int C_W       = 3 * T_W;
	localparam int C3_W      = C_W + 2 - 2 * FRAC_BITS;
	localparam int Q3_W      = Q_W + 2 - FRAC_BITS;
	localparam int L3_W      = T_W + 2;
	localparam int ONE_W     = FRAC_BITS + 1;

	localparam int MAX_A     = (C3_W > Q3_W) ? C3_W : Q3_W;
	localparam int MAX_B     = (L3_W > ONE_W) ? L3_W : ONE_W;
	// Three bits of headroom cover the sign and the additions of each weight.
	localparam int W_W       = ((MAX_A > MAX_B) ? MAX_A : MAX_B) + 3;
	localparam int P_W       = W_W + COORD_W;
	localparam int PS_W      = P_W + 1;
	localparam int ACC_W     = P_W + 2;
	localparam int SH_W      = ACC_W - FRAC_BITS;

	localparam int NUM_PTS   = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [W_W-1:0]     weight_t;
	typedef weight_t [NUM_PTS-1:0]     weights_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] p0_x;
		logic signed [COORD_W-1:0] p0_y;
		logic signed [COORD_W-1:0] p1_x;
		logic signed [COORD_W-1:0] p1_y;
		logic signed [COORD_W-1:0] p2_x;
		logic signed [COORD_W-1:0] p2_y;
		logic signed [COORD_W-1:0] p3_x;
		logic signed [COORD_W-1:0] p3_y;
		logic [T_W-1:0]            t_param;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
	} out_item_t;

	// Load enables of the first three pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

// File: sv/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator, six-stage pipeline.
// result_valid is the valid bit of s6; an accepted input is registered in s1 and moves through s2 to s6.
// Throughput: one transaction per cycle while the output is not stalled; the result register is the last stage,
// so a stalled output only holds the stages that are full behind it.
// Reset (arst_n, asynchronous, active low) clears the stage valid bits only.
// Depends on cbpe_pkg and cbpe_weights.
module cubic_bezier_point_eval import cbpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	// Stage plan:
	//   s1  t squared (weights unit), control points registered.
	//   s2  t cubed.
	//   s3  the four weights from shifts and adds.
	//   s4  eight products, one per weight and coordinate.
	//   s5  pairwise sums of the products.
	//   s6  final sum, arithmetic shift by FRAC_BITS, saturation; this is
	//       the output register.
	// Each stage loads when it is empty or the stage after it loads, so a
	// stall backs up stage by stage and no transaction is dropped or repeated.

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	adv_t adv_w;

	coord_t [NUM_PTS-1:0] px_in, py_in;
	coord_t [NUM_PTS-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	weights_t             weights;

	logic signed [P_W-1:0]  prod_x_s4 [NUM_PTS];
	logic signed [P_W-1:0]  prod_y_s4 [NUM_PTS];
	logic signed [PS_W-1:0] sum_x_s5  [2];
	logic signed [PS_W-1:0] sum_y_s5  [2];
	out_item_t              res_s6;

	logic signed [ACC_W-1:0] acc_x, acc_y;
	logic signed [SH_W-1:0]  sh_x, sh_y;
	out_item_t               sat;

	// Ready ripples back from the output through the empty/advance chain.
	assign adv6 = !v_s6 || result_ready;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign item_ready = adv1;
	assign adv_w      = '{s1: adv1, s2: adv2, s3: adv3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= item_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// The weights take three stages; the control points ride alongside.
	cbpe_weights u_weights (
		.clk     (clk),
		.adv     (adv_w),
		.t_param (item.t_param),
		.weights (weights)
	);

	assign px_in = {item.p3_x, item.p2_x, item.p1_x, item.p0_x};
	assign py_in = {item.p3_y, item.p2_y, item.p1_y, item.p0_y};

	always_ff @(posedge clk) begin
		if (adv1) begin
			px_s1 <= px_in;
			py_s1 <= py_in;
		end
		if (adv2) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
		if (adv3) begin
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
	end

	// Stage 4: one signed multiply per weight and coordinate.
	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int k = 0; k < NUM_PTS; k++) begin
				prod_x_s4[k] <= P_W'(weights[k]) * P_W'(px_s3[k]);
				prod_y_s4[k] <= P_W'(weights[k]) * P_W'(py_s3[k]);
			end
		end
	end

	// Stage 5: first level of the adder tree.
	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int j = 0; j < 2; j++) begin
				sum_x_s5[j] <= PS_W'(prod_x_s4[2*j]) + PS_W'(prod_x_s4[2*j+1]);
				sum_y_s5[j] <= PS_W'(prod_y_s4[2*j]) + PS_W'(prod_y_s4[2*j+1]);
			end
		end
	end

	// Stage 6: full sum, floor shift, then clamp into the 16-bit signed range.
	always_comb begin
		acc_x = ACC_W'(sum_x_s5[0]) + ACC_W'(sum_x_s5[1]);
		acc_y = ACC_W'(sum_y_s5[0]) + ACC_W'(sum_y_s5[1]);
		sh_x  = SH_W'(acc_x >>> FRAC_BITS);
		sh_y  = SH_W'(acc_y >>> FRAC_BITS);

		if (sh_x > $signed(SH_W'(32767))) begin
			sat.curve_x = 16'sh7FFF;
		end else if (sh_x < $signed(SH_W'(-32768))) begin
			sat.curve_x = 16'sh8000;
		end else begin
			sat.curve_x = COORD_W'(sh_x);
		end

		if (sh_y > $signed(SH_W'(32767))) begin
			sat.curve_y = 16'sh7FFF;
		end else if (sh_y < $signed(SH_W'(-32768))) begin
			sat.curve_y = 16'sh8000;
		end else begin
			sat.curve_y = COORD_W'(sh_y);
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			res_s6 <= sat;
		end
	end

	assign result_valid = v_s6;
	assign result       = res_s6;

endmodule

// File: sv/cbpe_weights.sv
// Three-stage pipeline that turns the curve parameter into the four Bernstein
// weights (t squared, t cubed, then shifts and adds). Depends on cbpe_pkg.
module cbpe_weights import cbpe_pkg::*; (
	input  logic           clk,
	input  adv_t           adv,
	input  logic [T_W-1:0] t_param,
	output weights_t       weights
);

	logic [T_W-1:0]    t_s1;
	logic [Q_W-1:0]    q_s1;
	logic [T_W-1:0]    t_s2;
	logic [Q_W-1:0]    q_s2;
	logic [C_W-1:0]    c_s2;
	weights_t          w_s3;

	logic [C_W+1:0]    c_x3;
	logic [Q_W+1:0]    q_x3;
	logic [C3_W-1:0]   c3;
	logic [Q3_W-1:0]   q3;
	logic [L3_W-1:0]   l3;
	logic [T_W+2-1:0]  cu;
	weight_t           c3_s;
	weight_t           q3_s;
	weight_t           l3_s;
	weight_t           cu_s;
	weight_t           one_s;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			t_s1 <= t_param;
			q_s1 <= Q_W'(t_param) * Q_W'(t_param);
		end
		if (adv.s2) begin
			t_s2 <= t_s1;
			q_s2 <= q_s1;
			c_s2 <= C_W'(q_s1) * C_W'(t_s1);
		end
		if (adv.s3) begin
			w_s3[0] <= one_s - cu_s + q3_s - l3_s;
			w_s3[1] <= c3_s - (q3_s <<< 1) + l3_s;
			w_s3[2] <= q3_s - c3_s;
			w_s3[3] <= cu_s;
		end
	end

	always_comb begin
		c_x3  = {c_s2, 1'b0} + (C_W+2)'(c_s2);
		q_x3  = {q_s2, 1'b0} + (Q_W+2)'(q_s2);
		c3    = C3_W'(c_x3 >> (2 * FRAC_BITS));
		q3    = Q3_W'(q_x3 >> FRAC_BITS);
		l3    = {t_s2, 1'b0} + L3_W'(t_s2);
		cu    = (T_W+2)'(c_s2 >> (2 * FRAC_BITS));
		c3_s  = W_W'(c3);
		q3_s  = W_W'(q3);
		l3_s  = W_W'(l3);
		cu_s  = W_W'(cu);
		one_s = W_W'(1) <<< FRAC_BITS;
	end

	assign weights = w_s3;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for cubic_bezier_point_eval: directed and random curve points are checked
// against a predictor of the fixed-point Bernstein evaluation, under random stalls.
// Depends on cbpe_pkg and the evaluator RTL.

module tb;
	import cbpe_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int RANDOM_POINTS = 1700;
	// The pipeline is six stages deep; this leaves room to catch a stray extra result.
	localparam int DRAIN_CYCLES  = 16;
	localparam int MAX_IDLE      = 12;
	localparam int ONE_T         = 1 << FRAC_BITS;
	localparam int MAX_T         = (1 << T_W) - 1;
	localparam longint COORD_MAX = 32767;
	localparam longint COORD_MIN = -32768;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;

	// Curve points predicted for accepted transactions, oldest first.
	out_item_t expected_points[$];
	int        errors       = 0;
	int        cycle_count  = 0;
	int        points_sent  = 0;
	// When clear, neither side inserts idle cycles, so the pipeline runs back to back.
	bit        idle_on      = 1'b1;

	cubic_bezier_point_eval DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// A hung handshake would otherwise stall the run forever.
	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("tb: FAIL");
		$finish;
	end

	// Arithmetic shift right by the fraction bits (floor), then clamp to 16 bits signed.
	function automatic coord_t scale_and_clamp(longint acc);
		longint v;
		v = acc >>> FRAC_BITS;
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return coord_t'(v);
	endfunction

	// Predicts the curve point. All terms are non-negative until the weights are
	// combined, so the truncating shifts match the block's; 64 bits hold every sum.
	function automatic out_item_t bezier_point(in_item_t p);
		longint    tt, sq, cb, c3, q3, l3, cu;
		longint    w0, w1, w2, w3;
		longint    acc_x, acc_y;
		coord_t    cx [NUM_PTS];
		coord_t    cy [NUM_PTS];
		out_item_t r;
		tt = longint'(p.t_param);
		sq = tt * tt;
		cb = sq * tt;
		c3 = (3 * cb) >> (2 * FRAC_BITS);
		q3 = (3 * sq) >> FRAC_BITS;
		l3 = 3 * tt;
		cu = cb >> (2 * FRAC_BITS);
		w0 = ONE_T - cu + q3 - l3;
		w1 = c3 - 2 * q3 + l3;
		w2 = q3 - c3;
		w3 = cu;
		cx[0] = p.p0_x; cx[1] = p.p1_x; cx[2] = p.p2_x; cx[3] = p.p3_x;
		cy[0] = p.p0_y; cy[1] = p.p1_y; cy[2] = p.p2_y; cy[3] = p.p3_y;
		acc_x = w0 * longint'(cx[0]) + w1 * longint'(cx[1])
		      + w2 * longint'(cx[2]) + w3 * longint'(cx[3]);
		acc_y = w0 * longint'(cy[0]) + w1 * longint'(cy[1])
		      + w2 * longint'(cy[2]) + w3 * longint'(cy[3]);
		r.curve_x = scale_and_clamp(acc_x);
		r.curve_y = scale_and_clamp(acc_y);
		return r;
	endfunction

	function automatic int draw_idle();
		return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
	endfunction

	// Coordinates lean on the rails so that saturation shows up often.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 7))
			0: return coord_t'(COORD_MAX);
			1: return coord_t'(COORD_MIN);
			2: return coord_t'(int'($urandom_range(0, 255)) - 128);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t make_point(int t);
		in_item_t p;
		p.p0_x = pick_coord(); p.p0_y = pick_coord();
		p.p1_x = pick_coord(); p.p1_y = pick_coord();
		p.p2_x = pick_coord(); p.p2_y = pick_coord();
		p.p3_x = pick_coord(); p.p3_y = pick_coord();
		p.t_param = T_W'(t);
		return p;
	endfunction

	function automatic in_item_t uniform_point(coord_t a, coord_t b, int t);
		in_item_t p;
		p.p0_x = a; p.p0_y = b;
		p.p1_x = a; p.p1_y = b;
		p.p2_x = a; p.p2_y = b;
		p.p3_x = a; p.p3_y = b;
		p.t_param = T_W'(t);
		return p;
	endfunction

	// Sends one transaction. The caller returns just after the accepting edge; valid is
	// left high so that a back-to-back transaction keeps it high without a glitch.
	task automatic send_point(in_item_t p);
		int gap;
		gap = draw_idle();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= p;
		do @(posedge clk); while (!item_ready);
		expected_points.push_back(bezier_point(p));
		points_sent++;
	endtask

	// Lowers valid and holds off until every predicted point has come back.
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	// A feeder sweep: t from zero in equal steps, always closing with t equal to one.
	task automatic send_sweep(in_item_t ctrl, int step);
		for (int t = 0; t < ONE_T; t += step) begin
			ctrl.t_param = T_W'(t);
			send_point(ctrl);
		end
		ctrl.t_param = T_W'(ONE_T);
		send_point(ctrl);
	endtask

	// At t = 0 the curve sits on the first control point, at t = 1 on the last.
	task automatic test_endpoints();
		send_point(make_point(0));
		send_point(make_point(ONE_T));
		send_point(uniform_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), 0));
		send_point(uniform_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), ONE_T));
		wait_drained();
	endtask

	// Rail coordinates, then extrapolation past t = 1 that drives both outputs into
	// saturation, positive on one axis and negative on the other.
	task automatic test_coordinate_extremes();
		in_item_t p;
		send_point(uniform_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), ONE_T / 2));
		p = uniform_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), ONE_T / 2);
		p.p1_x = coord_t'(COORD_MAX); p.p2_x = coord_t'(COORD_MAX);
		p.p1_y = coord_t'(COORD_MIN); p.p2_y = coord_t'(COORD_MIN);
		send_point(p);
		p = uniform_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), MAX_T);
		p.p3_x = coord_t'(COORD_MAX);
		p.p3_y = coord_t'(COORD_MIN);
		send_point(p);
		p.t_param = T_W'(ONE_T + 1);
		send_point(p);
		p = uniform_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), MAX_T);
		p.p3_x = coord_t'(COORD_MIN);
		p.p3_y = coord_t'(COORD_MAX);
		send_point(p);
		send_point(make_point(MAX_T));
		wait_drained();
	endtask

	task automatic test_sweep();
		send_sweep(make_point(0), ONE_T / 8);
		wait_drained();
	endtask

	// Phases of a few hundred points each. Most transactions are whole sweeps with
	// random control points and step; the rest are lone points with t anywhere in
	// the field, above one included. Idling is switched off in some phases so the
	// pipeline is also exercised full, and every phase ends with a full drain.
	task automatic test_random();
		int start;
		int phase_end;
		start = points_sent;
		while (points_sent - start < RANDOM_POINTS) begin
			idle_on   = ($urandom_range(0, 3) != 0);
			phase_end = points_sent + $urandom_range(100, 300);
			while (points_sent < phase_end && points_sent - start < RANDOM_POINTS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: send_sweep(make_point(0), $urandom_range(16, 128));
					7, 8: send_point(make_point($urandom_range(0, MAX_T)));
					default: send_point(make_point($urandom_range(ONE_T, MAX_T)));
				endcase
			end
			wait_drained();
		end
		idle_on = 1'b1;
	endtask

	// Takes each result transaction and compares it with the oldest prediction.
	initial begin : result_checker
		int        stall;
		out_item_t want;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_idle();
			@(negedge clk);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			if (expected_points.size() == 0) begin
				$error("unexpected result transaction: curve_x %0d, curve_y %0d",
				       result.curve_x, result.curve_y);
				errors++;
			end else begin
				want = expected_points.pop_front();
				if (result.curve_x !== want.curve_x) begin
					$error("curve_x: expected %0d, got %0d", want.curve_x, result.curve_x);
					errors++;
				end
				if (result.curve_y !== want.curve_y) begin
					$error("curve_y: expected %0d, got %0d", want.curve_y, result.curve_y);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_endpoints();
		test_coordinate_extremes();
		test_sweep();
		test_random();

		// Anything arriving during this window has no prediction and is flagged.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: files.f
sv/cbpe_pkg.sv
sv/cbpe_weights.sv
sv/cubic_bezier_point_eval.sv
verif/tb.sv
